/* hdl/fpadd_pkg.sv */
// Shared types and constants for the binary32 adder pipeline.
// No dependencies.
package fpadd_pkg;
  localparam logic [7:0]  ExpMax  = 8'hFF;
  localparam logic [31:0] InfBits = 32'h7F80_0000;
  localparam logic [31:0] NanOpp  = 32'h7F80_0001;

  // aligned operands after stage 1
  typedef struct packed {
    logic        special;
    logic [31:0] special_bits;
    logic        sign;
    logic        diff;
    logic [7:0]  exp;
    logic [26:0] sa;
    logic [26:0] sb;
  } align_t;

  // raw sum after stage 2
  typedef struct packed {
    logic        special;
    logic [31:0] special_bits;
    logic        sign;
    logic        diff;
    logic [7:0]  exp;
    logic [27:0] sum;
  } sum_t;

  // normalised sum after stage 3
  typedef struct packed {
    logic        special;
    logic [31:0] special_bits;
    logic        sign;
    logic [8:0]  exp;
    logic [26:0] sig;
  } norm_t;
endpackage

/* hdl/fpadd_align.sv */
// Stage 1: special cases, magnitude swap and alignment shift.
// Depends on fpadd_pkg.
module fpadd_align (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_in,
  input  logic [31:0]          operand_a,
  input  logic [31:0]          operand_b,
  output logic                 valid_out,
  output fpadd_pkg::align_t    stage_out
);
  import fpadd_pkg::*;

  logic [7:0]  ea, eb, el, es, d;
  logic [22:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [31:0] big, sml;
  logic [26:0] sl, ss, shifted, lost_mask;
  align_t      a_next;

  always_comb begin
    ea = operand_a[30:23];
    eb = operand_b[30:23];
    fa = operand_a[22:0];
    fb = operand_b[22:0];
    a_nan = (ea == ExpMax) && (fa != '0);
    b_nan = (eb == ExpMax) && (fb != '0);
    a_inf = (ea == ExpMax) && (fa == '0);
    b_inf = (eb == ExpMax) && (fb == '0);
    swap = operand_b[30:0] > operand_a[30:0];
    big = swap ? operand_b : operand_a;
    sml = swap ? operand_a : operand_b;
    el = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    sl = {(big[30:23] != 8'd0), big[22:0], 3'b000};
    ss = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
    d  = el - es;
    lost_mask = '0;
    // shift right with sticky
    if (d >= 8'd27) begin
      shifted = {26'd0, (ss != '0)};
    end else begin
      lost_mask = ~(27'h7FF_FFFF << d[4:0]);
      shifted = (ss >> d[4:0]) | {26'd0, ((ss & lost_mask) != '0)};
    end
    a_next.sign = big[31];
    a_next.diff = big[31] ^ sml[31];
    a_next.exp  = el;
    a_next.sa   = sl;
    a_next.sb   = shifted;
    a_next.special = a_nan || b_nan || a_inf || b_inf;
    priority if (a_nan) begin
      a_next.special_bits = operand_a;
    end else if (b_nan) begin
      a_next.special_bits = operand_b;
    end else if (a_inf && b_inf) begin
      a_next.special_bits = (operand_a[31] != operand_b[31]) ? NanOpp : operand_a;
    end else if (a_inf) begin
      a_next.special_bits = operand_a;
    end else begin
      a_next.special_bits = operand_b;
    end
  end

  // advance stage register
  always_ff @(posedge clk) begin
    if (rst) valid_out <= 1'b0;
    else     valid_out <= valid_in;
    stage_out <= a_next;
  end
endmodule

/* hdl/fpadd_addnorm.sv */
// Stages 2 and 3: significand add/subtract, then normalisation.
// Depends on fpadd_pkg.
module fpadd_addnorm (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid_in,
  input  fpadd_pkg::align_t stage_in,
  output logic              valid_out,
  output fpadd_pkg::norm_t  stage_out
);
  import fpadd_pkg::*;

  sum_t        s2, s2_next;
  logic        v2;
  norm_t       n_next;
  logic [4:0]  lz;
  logic [4:0]  sh;
  logic [8:0]  room;

  // add or subtract
  always_comb begin
    s2_next.special      = stage_in.special;
    s2_next.special_bits = stage_in.special_bits;
    s2_next.sign = stage_in.sign;
    s2_next.diff = stage_in.diff;
    s2_next.exp  = stage_in.exp;
    s2_next.sum  = stage_in.diff ? ({1'b0, stage_in.sa} - {1'b0, stage_in.sb})
                                 : ({1'b0, stage_in.sa} + {1'b0, stage_in.sb});
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= valid_in;
    s2 <= s2_next;
  end

  // leading-zero count over bits 26..0
  always_comb begin
    lz = 5'd26;
    for (int i = 0; i <= 26; i++) begin
      if (s2.sum[i]) lz = 5'(26 - i);
    end
  end

  // normalise; keep a special result even when the significands cancel
  always_comb begin
    n_next.special      = s2.special;
    n_next.special_bits = s2.special_bits;
    n_next.sign = s2.sign;
    room = {1'b0, s2.exp} - 9'd1;
    sh = ({4'd0, lz} > room) ? room[4:0] : lz;
    if (s2.sum == '0) begin
      n_next.special = 1'b1;
      n_next.special_bits = s2.special ? s2.special_bits
                                       : (s2.diff ? 32'd0 : {s2.sign, 31'd0});
      n_next.exp = '0;
      n_next.sig = '0;
    end else if (s2.sum[27]) begin
      n_next.exp = {1'b0, s2.exp} + 9'd1;
      n_next.sig = s2.sum[27:1] | {26'd0, s2.sum[0]};
    end else begin
      n_next.exp = {1'b0, s2.exp} - {4'd0, sh};
      n_next.sig = s2.sum[26:0] << sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid_out <= 1'b0;
    else     valid_out <= v2;
    stage_out <= n_next;
  end
endmodule

/* hdl/fpadd_round.sv */
// Stage 4: round to nearest even and pack the result.
// Depends on fpadd_pkg.
module fpadd_round (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid_in,
  input  fpadd_pkg::norm_t stage_in,
  output logic             valid_out,
  output logic [31:0]      result
);
  import fpadd_pkg::*;

  logic [24:0] mant;
  logic [2:0]  rem;
  logic [8:0]  e;
  logic [31:0] r_next;

  always_comb begin
    rem  = stage_in.sig[2:0];
    mant = {1'b0, stage_in.sig[26:3]};
    e    = stage_in.exp;
    if (rem > 3'd4 || (rem == 3'd4 && mant[0])) mant = mant + 25'd1;
    if (mant[24]) begin
      mant = mant >> 1;
      e = e + 9'd1;
    end
    if (stage_in.special)      r_next = stage_in.special_bits;
    else if (e >= 9'd255)      r_next = {stage_in.sign, 31'd0} | InfBits;
    else r_next = {stage_in.sign, (mant[23] ? e[7:0] : 8'd0), mant[22:0]};
  end

  // drive result register
  always_ff @(posedge clk) begin
    if (rst) valid_out <= 1'b0;
    else     valid_out <= valid_in;
    result <= r_next;
  end
endmodule

/* hdl/binary32_float_adder_unit.sv */
// Binary32 adder, four register stages: align, add, normalise, round.
// One request per cycle.
// busy is always low: the pipeline never stalls.
// Synchronous active-high reset clears all valid bits; data needs no reset.
// Depends on fpadd_pkg, fpadd_align, fpadd_addnorm, fpadd_round.
module binary32_float_adder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        done,
  output logic [31:0] sum_bits
);
  import fpadd_pkg::*;

  logic   v1, v3;
  align_t st1;
  norm_t  st3;

  assign busy = 1'b0;

  fpadd_align u_align (
    .clk(clk), .rst(rst), .valid_in(start && !busy),
    .operand_a(operand_a), .operand_b(operand_b),
    .valid_out(v1), .stage_out(st1)
  );

  fpadd_addnorm u_addnorm (
    .clk(clk), .rst(rst), .valid_in(v1), .stage_in(st1),
    .valid_out(v3), .stage_out(st3)
  );

  fpadd_round u_round (
    .clk(clk), .rst(rst), .valid_in(v3), .stage_in(st3),
    .valid_out(done), .result(sum_bits)
  );
endmodule

/* hdl/fpadd_checker.sv */
// Port-level checks for binary32_float_adder_unit, attached by bind.
// No package dependencies.
module fpadd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] operand_a,
  input logic [31:0] operand_b,
  input logic [31:0] sum_bits
);
  // every request gives a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done) else $error("missing result");
  // no result without a request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 4)) else $error("spurious result");
  // NaN in operand_a comes back unchanged
  a_nan_a: assert property (@(posedge clk) disable iff (rst)
    (start && operand_a[30:23] == 8'hFF && operand_a[22:0] != 23'd0)
      |-> ##4 (sum_bits == $past(operand_a, 4))) else $error("NaN not kept");
  // x + 0 returns x for nonzero finite x
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (start && operand_b == 32'd0 && operand_a[30:23] != 8'hFF && operand_a[30:0] != 31'd0)
      |-> ##4 (sum_bits == $past(operand_a, 4))) else $error("x+0 wrong");
endmodule

bind binary32_float_adder_unit fpadd_checker u_fpadd_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .operand_a(operand_a), .operand_b(operand_b), .sum_bits(sum_bits)
);
